[hw/rtl/lsid_pkg.sv]
// Shared constants, types and a helper function for the table-seeded divider.
package lsid_pkg;

  localparam int unsigned P_INDEX_BITS = 5;
  localparam int unsigned P_DATA_WIDTH = 64;
  localparam int unsigned P_ENTRY_BITS = 16;

  // residue, estimate and accumulator width, as wide as the widest operand
  localparam int unsigned X_W        = 64;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned STEP_MAX   = 127;
  localparam int unsigned GUARD_W    = 13;
  localparam int unsigned STEP_GUARD = 4096;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DIV0 = 1'b1;

  function automatic int rom_shift(int ib, int eb);
    int s;
    s = eb - 1 - ib;
    return (s < 1) ? 1 : s;
  endfunction

  typedef struct packed {
    logic load;
    logic setup;
    logic zero;
    logic lzx;
    logic shift;
    logic mul_step;
    logic update;
    logic finish;
  } lsid_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic a_zero;
    logic mul_last;
    logic done_loop;
  } lsid_sts_t;

endpackage

[hw/rtl/lsid_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsid_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/lsid_rom_fill.sv]
// Post-reset sweep that computes each estimate with a bit-serial divider and writes the ROM.
module lsid_rom_fill
  import lsid_pkg::*;
#(
  parameter int unsigned INDEX_BITS = P_INDEX_BITS,
  parameter int unsigned ENTRY_BITS = P_ENTRY_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output logic                    we,
  output logic [2*INDEX_BITS-1:0] waddr,
  output logic [ENTRY_BITS-1:0]   wdata,
  output logic                    done
);

  localparam int unsigned AW    = 2 * INDEX_BITS;
  localparam int unsigned SH    = rom_shift(INDEX_BITS, ENTRY_BITS);
  localparam int unsigned NUM_W = INDEX_BITS + 1 + SH;
  localparam int unsigned DEN_W = INDEX_BITS + 1;
  localparam int unsigned CW    = $clog2(NUM_W + 2);

  logic [AW:0]        idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den;
  logic [DEN_W:0]     trial;
  logic               fits;

  assign den   = {1'b1, idx_r[INDEX_BITS-1:0]};
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_comb begin
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (!done_r) begin
      if (cnt_r == '0) begin
        num_nxt = NUM_W'({1'b1, idx_r[AW-1:INDEX_BITS]}) << SH;
        quo_nxt = '0;
        rem_nxt = '0;
        cnt_nxt = cnt_r + 1'b1;
      end else if (cnt_r == CW'(NUM_W + 1)) begin
        // entry written this cycle; advance to the next one
        cnt_nxt = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r[AW-1:0] == {AW{1'b1}}) begin
          done_nxt = 1'b1;
        end
      end else begin
        rem_nxt = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        quo_nxt = {quo_r[NUM_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign we    = !done_r && (cnt_r == CW'(NUM_W + 1));
  assign waddr = idx_r[AW-1:0];
  assign wdata = ENTRY_BITS'(quo_r);
  assign done  = done_r;

endmodule

[hw/rtl/lsid_dpath.sv]
// Divider datapath: leading-one search, ROM addressing, estimate shift, serial multiply, residue update.
module lsid_dpath
  import lsid_pkg::*;
#(
  parameter int unsigned INDEX_BITS = P_INDEX_BITS,
  parameter int unsigned DATA_WIDTH = P_DATA_WIDTH,
  parameter int unsigned ENTRY_BITS = P_ENTRY_BITS
) (
  input  logic                    clk,
  input  lsid_cmd_t               cmd,
  output lsid_sts_t               sts,
  input  logic [DATA_WIDTH-1:0]   in_dividend,
  input  logic [DATA_WIDTH-1:0]   in_divisor,
  output logic [2*INDEX_BITS-1:0] rom_addr,
  input  logic [ENTRY_BITS-1:0]   rom_data,
  output logic [DATA_WIDTH-1:0]   out_quotient,
  output logic [DATA_WIDTH-1:0]   out_remainder,
  output logic                    out_status,
  output logic [STEP_W-1:0]       out_step_count
);

  localparam int unsigned PW    = $clog2(DATA_WIDTH);
  localparam int unsigned SH    = rom_shift(INDEX_BITS, ENTRY_BITS);
  localparam int unsigned SFT_W = PW + 8;
  localparam int unsigned P_W   = 2 * X_W;

  function automatic logic [PW-1:0] lead_pos(logic [X_W-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int k = 0; k < DATA_WIDTH; k++) begin
      if (v[k]) p = PW'(k);
    end
    return p;
  endfunction

  function automatic logic [INDEX_BITS-1:0] index_bits(logic [X_W-1:0] v, logic [PW-1:0] p);
    logic [X_W-1:0] t;
    if (p >= PW'(INDEX_BITS)) t = v >> (p - PW'(INDEX_BITS));
    else                      t = v << (PW'(INDEX_BITS) - p);
    return t[INDEX_BITS-1:0];
  endfunction

  logic [X_W-1:0]        x_r, acc_r, gq_r;
  logic [DATA_WIDTH-1:0] b_r;
  logic                  neg_r;
  logic [STEP_W-1:0]     steps_r;
  logic [GUARD_W-1:0]    iter_r;
  logic [PW-1:0]         pb_r, px_r;
  logic [INDEX_BITS-1:0] ib_r;
  logic [1:0]            mi_r;
  logic [P_W-1:0]        prod_r;
  logic [DATA_WIDTH-1:0] q_r, r_r;
  logic                  status_r;
  logic [STEP_W-1:0]     cnt_out_r;

  logic [X_W-1:0]          b64;
  logic signed [SFT_W-1:0] sft;
  logic [SFT_W-1:0]        nmag;
  logic [X_W-1:0]          gq_nxt;
  logic [MUL_W-1:0]        ma, mb;
  logic [2*MUL_W-1:0]      pp;
  logic [1:0]              pos;
  logic [X_W-1:0]          hi, lo, dres;
  logic                    over;

  assign b64      = X_W'(b_r);
  assign rom_addr = {index_bits(x_r, px_r), ib_r};

  assign sft    = $signed(SFT_W'(px_r)) - $signed(SFT_W'(pb_r)) - $signed(SFT_W'(SH));
  assign nmag   = SFT_W'(-sft);
  assign gq_nxt = sft[SFT_W-1] ? (X_W'(rom_data) >> nmag) : (X_W'(rom_data) << sft);

  assign ma  = mi_r[1] ? gq_r[2*MUL_W-1:MUL_W] : gq_r[MUL_W-1:0];
  assign mb  = mi_r[0] ? b64[2*MUL_W-1:MUL_W] : b64[MUL_W-1:0];
  assign pp  = ma * mb;
  assign pos = {1'b0, mi_r[1]} + {1'b0, mi_r[0]};

  assign hi   = prod_r[P_W-1:X_W];
  assign lo   = prod_r[X_W-1:0];
  assign over = (hi != '0) || (lo > x_r);
  assign dres = over ? (lo - x_r) : (x_r - lo);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= X_W'(in_dividend);
      b_r     <= in_divisor;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      steps_r <= '0;
      iter_r  <= '0;
    end
    if (cmd.setup) begin
      pb_r <= lead_pos(b64);
      ib_r <= index_bits(b64, lead_pos(b64));
    end
    if (cmd.lzx) begin
      px_r <= lead_pos(x_r);
    end
    if (cmd.shift) begin
      gq_r   <= gq_nxt;
      prod_r <= '0;
      mi_r   <= '0;
    end
    if (cmd.mul_step) begin
      // accumulate one 32x32 partial product at its place
      prod_r <= prod_r + (P_W'(pp) << {pos, 5'b0});
      mi_r   <= mi_r + 1'b1;
    end
    if (cmd.update) begin
      acc_r  <= neg_r ? (acc_r - gq_r) : (acc_r + gq_r);
      neg_r  <= neg_r ^ over;
      x_r    <= dres;
      iter_r <= iter_r + 1'b1;
      if (steps_r != STEP_W'(STEP_MAX)) begin
        steps_r <= steps_r + 1'b1;
      end
    end
    if (cmd.zero) begin
      q_r       <= '0;
      r_r       <= '0;
      cnt_out_r <= '0;
      status_r  <= (b_r == '0) ? STATUS_DIV0 : STATUS_OK;
    end
    if (cmd.finish) begin
      // an overshoot leaves a negative residue: step the quotient back by one
      if (!neg_r || x_r == '0) begin
        q_r <= acc_r[DATA_WIDTH-1:0];
        r_r <= x_r[DATA_WIDTH-1:0];
      end else begin
        q_r <= DATA_WIDTH'(acc_r - 1'b1);
        r_r <= DATA_WIDTH'(b64 - x_r);
      end
      cnt_out_r <= steps_r;
      status_r  <= STATUS_OK;
    end
  end

  assign sts.b_zero    = (b_r == '0);
  assign sts.a_zero    = (x_r == '0);
  assign sts.mul_last  = (mi_r == 2'd3);
  assign sts.done_loop = (x_r < b64) || (iter_r == GUARD_W'(STEP_GUARD));

  assign out_quotient   = q_r;
  assign out_remainder  = r_r;
  assign out_status     = status_r;
  assign out_step_count = cnt_out_r;

endmodule

[hw/rtl/lsid_ctrl.sv]
// Divider controller: sequences table fill, setup, refinement steps and result strobe.
module lsid_ctrl
  import lsid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      fill_done,
  input  lsid_sts_t sts,
  output lsid_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_SETUP, S_LZX, S_ADDR, S_SHIFT,
    S_MUL, S_UPD, S_TEST, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_FILL: begin
        if (fill_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.b_zero || sts.a_zero) begin
          cmd.zero  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LZX;
        end
      end
      S_LZX: begin
        cmd.lzx   = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_TEST;
      end
      S_TEST: begin
        state_nxt = sts.done_loop ? S_FIN : S_LZX;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      valid_r <= (state_nxt == S_OUT);
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

[hw/rtl/lut_seeded_integer_divider.sv]
// Top level of the table-seeded unsigned integer divider.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | start & !busy        | in_dividend, in_divisor
//   result   | out_valid (1 cycle)  | out_quotient, out_remainder, out_status,
//            |                      | out_step_count
//
// After reset the estimate ROM is filled by a bit-serial divider sweep over all
// 2^(2*INDEX_BITS) entries, with busy high. Each accepted item runs refinement steps until
// the strobe: each step is a leading-one search, a ROM read, a shift, four passes of one
// 32x32 multiplier, an update and a loop-end test. A zero divisor or dividend skips the steps.
// One item at a time; results cannot be stalled.
module lut_seeded_integer_divider
  import lsid_pkg::*;
#(
  parameter int unsigned INDEX_BITS = P_INDEX_BITS,
  parameter int unsigned DATA_WIDTH = P_DATA_WIDTH,
  parameter int unsigned ENTRY_BITS = P_ENTRY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_dividend,
  input  logic [DATA_WIDTH-1:0] in_divisor,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_quotient,
  output logic [DATA_WIDTH-1:0] out_remainder,
  output logic                  out_status,
  output logic [STEP_W-1:0]     out_step_count
);

  localparam int unsigned AW = 2 * INDEX_BITS;

  lsid_cmd_t             cmd;
  lsid_sts_t             sts;
  logic                  fill_done, fill_we;
  logic [AW-1:0]         fill_addr, rom_addr;
  logic [ENTRY_BITS-1:0] fill_data, rom_data;

  lsid_rom_fill #(
    .INDEX_BITS(INDEX_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_fill (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data),
    .done (fill_done)
  );

  lsid_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(1 << AW)
  ) u_rom (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data),
    .raddr(rom_addr),
    .rdata(rom_data)
  );

  lsid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .fill_done(fill_done),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  lsid_dpath #(
    .INDEX_BITS(INDEX_BITS),
    .DATA_WIDTH(DATA_WIDTH),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .in_dividend   (in_dividend),
    .in_divisor    (in_divisor),
    .rom_addr      (rom_addr),
    .rom_data      (rom_data),
    .out_quotient  (out_quotient),
    .out_remainder (out_remainder),
    .out_status    (out_status),
    .out_step_count(out_step_count)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_DIV0 |->
      out_quotient == '0 && out_remainder == '0 && out_step_count == '0)
    else $error("divide-by-zero result not cleared");

  a_no_strobe_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> !out_valid && busy)
    else $error("result or accept during table fill");
`endif

endmodule

[verif/tb_lut_seeded_integer_divider.sv]
// Self-checking testbench for the table-seeded unsigned integer divider.
module tb_lut_seeded_integer_divider;
  timeunit 1ns;
  timeprecision 1ps;
  import lsid_pkg::*;

  localparam int unsigned IB = P_INDEX_BITS;
  localparam int unsigned DW = P_DATA_WIDTH;
  localparam int unsigned EB = P_ENTRY_BITS;
  localparam int unsigned SIDE = 1 << IB;
  localparam longint unsigned CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_item_t;

  typedef struct {
    logic [DW-1:0]     quotient;
    logic [DW-1:0]     remainder;
    logic              status;
    logic [STEP_W-1:0] steps;
  } div_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [DW-1:0] in_dividend = '0;
  logic [DW-1:0] in_divisor = '0;
  logic out_valid;
  logic [DW-1:0] out_quotient;
  logic [DW-1:0] out_remainder;
  logic out_status;
  logic [STEP_W-1:0] out_step_count;

  div_item_t   pending_items[$];
  div_result_t expected_results[$];
  logic [31:0] seed_table[SIDE*SIDE];
  int  errors = 0;
  int  send_idle_pct = 0;
  bit  hold_sender = 1'b0;
  bit  stim_done = 1'b0;
  longint unsigned cycles = 0;

  lut_seeded_integer_divider uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dividend(in_dividend), .in_divisor(in_divisor),
    .out_valid(out_valid), .out_quotient(out_quotient),
    .out_remainder(out_remainder), .out_status(out_status),
    .out_step_count(out_step_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int seed_shift();
    int s;
    s = EB - 1 - IB;
    return (s < 1) ? 1 : s;
  endfunction

  function automatic int leading_one(logic [DW-1:0] v);
    for (int p = DW - 1; p > 0; p--) if (v[p]) return p;
    return 0;
  endfunction

  function automatic logic [IB-1:0] mantissa_bits(logic [DW-1:0] v, int p);
    logic [DW-1:0] t;
    t = (p >= IB) ? (v >> (p - IB)) : (v << (IB - p));
    return t[IB-1:0];
  endfunction

  function automatic div_result_t divide(div_item_t it);
    div_result_t r;
    logic [DW-1:0] x, acc, gq, d, est;
    logic [2*DW-1:0] prod;
    bit neg;
    int steps, pb, px, sft, sh;
    logic [IB-1:0] ib, ix;
    r = '{default: '0};
    if (it.divisor == 0) begin
      r.status = STATUS_DIV0;
      return r;
    end
    if (it.dividend == 0) return r;
    sh = seed_shift();
    x = it.dividend;
    acc = '0;
    neg = 1'b0;
    steps = 0;
    pb = leading_one(it.divisor);
    ib = mantissa_bits(it.divisor, pb);
    for (int i = 0; i < STEP_GUARD; i++) begin
      px = leading_one(x);
      ix = mantissa_bits(x, px);
      est = DW'(seed_table[ix * SIDE + ib]);
      sft = (px - pb) - sh;
      if (sft >= 0) gq = (sft < 64) ? (est << sft) : '0;
      else gq = (-sft < 64) ? (est >> (-sft)) : '0;
      prod = {{DW{1'b0}}, gq} * {{DW{1'b0}}, it.divisor};
      steps++;
      acc = neg ? acc - gq : acc + gq;
      if (prod > {{DW{1'b0}}, x}) begin
        d = prod[DW-1:0] - x;
        neg = !neg;
      end else begin
        d = x - prod[DW-1:0];
      end
      x = d;
      if (x < it.divisor) break;
    end
    if (!neg || x == 0) begin
      r.quotient = acc;
      r.remainder = x;
    end else begin
      r.quotient = acc - 1;
      r.remainder = it.divisor - x;
    end
    r.steps = (steps > STEP_MAX) ? STEP_W'(STEP_MAX) : STEP_W'(steps);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [DW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // random value with a random bit length, so small and large operands both occur
  function automatic logic [DW-1:0] rand_sized();
    int n;
    n = $urandom_range(1, DW);
    return rand_word() >> (DW - n);
  endfunction

  function automatic void push(logic [DW-1:0] a, logic [DW-1:0] b);
    div_item_t it;
    it.dividend = a;
    it.divisor = b;
    pending_items.push_back(it);
  endfunction

  // driver: present the next item and hold start until it is taken, then present the following one or drop start
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(divide('{in_dividend, in_divisor}));
        void'(pending_items.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          div_item_t nx;
          nx = pending_items[0];
          start <= 1'b1;
          in_dividend <= nx.dividend;
          in_divisor <= nx.divisor;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        div_result_t e;
        e = expected_results.pop_front();
        if (out_quotient !== e.quotient) report_mismatch("quotient", out_quotient, e.quotient);
        if (out_remainder !== e.remainder)
          report_mismatch("remainder", out_remainder, e.remainder);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_step_count !== e.steps)
          report_mismatch("step_count", out_step_count, e.steps);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [DW-1:0] b;
    for (int n = 0; n < SIDE; n++)
      for (int m = 0; m < SIDE; m++)
        seed_table[n * SIDE + m] = ((SIDE + n) << seed_shift()) / (SIDE + m);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero divisor, zero dividend, small dividend, extremes
    push(64'd0, 64'd0);
    push(64'd123, 64'd0);
    push('1, 64'd0);
    push(64'd0, 64'd7);
    push(64'd0, '1);
    push(64'd5, 64'd9);
    push(64'd1, '1);
    push('1, 64'd1);
    push('1, '1);
    push('1, 64'd2);
    push('1, 64'd3);
    push(64'h8000_0000_0000_0000, 64'd1);
    push(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    push('1, 64'h8000_0000_0000_0000);
    push(64'd1, 64'd1);
    push(64'd100, 64'd10);
    push(64'h5555_5555_5555_5555, 64'hAAAA_AAAA);
    push(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555);
    push('1, 64'h0000_0001_FFFF_FFFF);
    push(64'hFFFF_FFFF_0000_0000, 64'h1_0000_0001);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 84 : 0;
      for (int i = 0; i < 530; i++) begin
        case ($urandom_range(0, 19))
          0: push(rand_word(), 64'd0);
          1: push(64'd0, rand_sized());
          2: begin
            b = rand_sized();
            push(b >> $urandom_range(1, 8), (b == 0) ? 64'd1 : b);
          end
          3: push(rand_word(), rand_word());
          default: begin
            b = rand_sized();
            push(rand_sized(), (b == 0) ? 64'd3 : b);
          end
        endcase
        // pause the sender until all results are back once per phase
        if (i == 250) begin
          wait_drained();
          hold_sender = 1'b1;
          repeat (20) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
